// ===== sv/fpba_pkg.sv =====
// Shared constants, types and command codes of the fit policy block allocator.
`timescale 1ns / 1ps
package fpba_pkg;

  localparam int TOTAL_BYTES  = 1024;
  localparam int HEADER_BYTES = 24;
  localparam int MAX_BLOCKS   = 32;

  localparam int ADDR_W = 10;
  localparam int SIZE_W = 11;
  localparam int SLOT_W = $clog2(MAX_BLOCKS);
  localparam int IDX_W  = $clog2(MAX_BLOCKS + 1);
  localparam int MODE_W = 2;
  localparam int OP_W   = 2;
  localparam int STS_W  = 2;

  localparam logic [IDX_W-1:0]  CHAIN_END = IDX_W'(MAX_BLOCKS);
  localparam logic [SIZE_W-1:0] HDR_S     = SIZE_W'(HEADER_BYTES);
  localparam logic [SIZE_W-1:0] ARENA_S   = SIZE_W'(TOTAL_BYTES - HEADER_BYTES);

  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
  localparam logic [OP_W-1:0] OP_REINIT = 2'd2;

  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

  localparam logic [STS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STS_W-1:0] STS_NO_FIT  = 2'd1;
  localparam logic [STS_W-1:0] STS_NULL    = 2'd2;
  localparam logic [STS_W-1:0] STS_UNKNOWN = 2'd3;

  typedef enum logic [2:0] {
    CMD_IDLE,
    CMD_LOAD,
    CMD_WALK,
    CMD_SPLIT,
    CMD_AFIN,
    CMD_MNEXT,
    CMD_MPREV,
    CMD_FIN
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
  } fpba_cmd_t;

  typedef struct packed {
    logic walk_end;
    logic found;
    logic op_alloc;
    logic walk_op;
    logic out_busy;
  } fpba_sts_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] size;
    logic              free;
    logic [IDX_W-1:0]  next;
  } rec_t;

endpackage

// ===== sv/fpba_ctrl.sv =====
// Request sequencer of the fit policy block allocator.
`timescale 1ns / 1ps
module fpba_ctrl import fpba_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  fpba_sts_t sts_i,
  output fpba_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_WALK  = 7'b0000010,
    S_SPLIT = 7'b0000100,
    S_AFIN  = 7'b0001000,
    S_MNEXT = 7'b0010000,
    S_MPREV = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    cmd_o.cmd = CMD_IDLE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cmd = CMD_LOAD;
          state_d   = sts_i.walk_op ? S_WALK : S_DONE;
        end
      end
      S_WALK: begin
        if (sts_i.walk_end) begin
          if (!sts_i.found) state_d = S_DONE;
          else if (sts_i.op_alloc) state_d = S_SPLIT;
          else state_d = S_MNEXT;
        end else begin
          cmd_o.cmd = CMD_WALK;
        end
      end
      S_SPLIT: begin
        cmd_o.cmd = CMD_SPLIT;
        state_d   = S_AFIN;
      end
      S_AFIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.cmd = CMD_AFIN;
          state_d   = S_IDLE;
        end
      end
      S_MNEXT: begin
        cmd_o.cmd = CMD_MNEXT;
        state_d   = S_MPREV;
      end
      S_MPREV: begin
        if (!sts_i.out_busy) begin
          cmd_o.cmd = CMD_MPREV;
          state_d   = S_IDLE;
        end
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.cmd = CMD_FIN;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/fpba_dp.sv =====
// Record table, chain walker, split and merge datapath of the allocator.
`timescale 1ns / 1ps
module fpba_dp import fpba_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fpba_cmd_t         cmd_i,
  output fpba_sts_t         sts_o,
  input  logic [OP_W-1:0]   op_i,
  input  logic [SIZE_W-1:0] need_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic              cfg_we_i,
  input  logic [MODE_W-1:0] cfg_mode_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [STS_W-1:0]  out_status_o,
  output logic [ADDR_W-1:0] out_paddr_o,
  output logic [SIZE_W-1:0] out_gsize_o
);

  rec_t                 tab_q [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] valid_q, valid_d;
  logic [MODE_W-1:0]    mode_q;

  logic [OP_W-1:0]   op_q;
  logic [SIZE_W-1:0] need_q;
  logic [ADDR_W-1:0] addr_q;
  logic [IDX_W-1:0]  cur_q;
  logic [IDX_W-1:0]  steps_q;
  logic              stop_q, found_q;
  logic [SLOT_W-1:0] hit_slot_q;
  rec_t              hit_q;
  logic              prv_q;
  logic [SLOT_W-1:0] prv_slot_q;
  rec_t              prv_rec_q;
  logic              split_q;
  logic [SLOT_W-1:0] new_q;

  logic              out_valid_q;
  logic [STS_W-1:0]  out_status_q;
  logic [ADDR_W-1:0] out_paddr_q;
  logic [SIZE_W-1:0] out_gsize_q;

  logic [IDX_W-1:0]  rd_idx;
  logic [SLOT_W-1:0] rd_slot;
  rec_t              rd_rec;
  logic              rd_live;
  logic              cur_live;
  logic              cand, take_alloc, match;
  logic              spare_ok;
  logic [SLOT_W-1:0] spare_slot;
  logic [SIZE_W:0]   split_lim;
  logic              split_cond;
  logic [SIZE_W-1:0] merged_size;

  logic              wr_en;
  logic [SLOT_W-1:0] wr_slot;
  rec_t              wr_rec;
  logic              clr_en;
  logic [SLOT_W-1:0] clr_slot;
  logic              fin_en;
  logic [STS_W-1:0]  fin_status;
  logic [ADDR_W-1:0] fin_paddr;
  logic [SIZE_W-1:0] fin_gsize;
  logic              do_init;

  assign rd_idx   = (cmd_i.cmd == CMD_MNEXT) ? hit_q.next : cur_q;
  assign rd_slot  = rd_idx[SLOT_W-1:0];
  assign rd_rec   = tab_q[rd_slot];
  assign rd_live  = (rd_idx < CHAIN_END) && valid_q[rd_slot];
  assign cur_live = (cur_q < CHAIN_END) && valid_q[cur_q[SLOT_W-1:0]];

  assign cand = rd_rec.free && (rd_rec.size >= need_q);
  always_comb begin
    take_alloc = 1'b0;
    unique case (mode_q)
      MODE_FIRST: take_alloc = cand;
      MODE_BEST:  take_alloc = cand && (!found_q || rd_rec.size < hit_q.size);
      MODE_WORST: take_alloc = cand && (!found_q || rd_rec.size > hit_q.size);
      default:    take_alloc = 1'b0;
    endcase
  end
  assign match = ({1'b0, rd_rec.start} + HDR_S) == {1'b0, addr_q};

  always_comb begin
    spare_ok   = 1'b0;
    spare_slot = '0;
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        spare_ok   = 1'b1;
        spare_slot = SLOT_W'(i);
      end
    end
  end

  assign split_lim   = {1'b0, need_q} + {1'b0, HDR_S};
  assign split_cond  = {1'b0, hit_q.size} > split_lim;
  assign merged_size = prv_rec_q.size + HDR_S + hit_q.size;

  assign sts_o.walk_end = stop_q || !cur_live || (steps_q == CHAIN_END);
  assign sts_o.found    = found_q;
  assign sts_o.op_alloc = (op_q == OP_ALLOC);
  assign sts_o.walk_op  = (op_i == OP_ALLOC) || ((op_i == OP_FREE) && (addr_i != '0));
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  always_comb begin
    wr_en      = 1'b0;
    wr_slot    = hit_slot_q;
    wr_rec     = hit_q;
    clr_en     = 1'b0;
    clr_slot   = hit_slot_q;
    fin_en     = 1'b0;
    fin_status = STS_OK;
    fin_paddr  = '0;
    fin_gsize  = '0;
    do_init    = 1'b0;
    unique case (cmd_i.cmd)
      CMD_SPLIT: begin
        if (split_cond && spare_ok) begin
          wr_en        = 1'b1;
          wr_slot      = spare_slot;
          wr_rec.start = ADDR_W'({1'b0, hit_q.start} + HDR_S + need_q);
          wr_rec.size  = hit_q.size - need_q - HDR_S;
          wr_rec.free  = 1'b1;
          wr_rec.next  = hit_q.next;
        end
      end
      CMD_AFIN: begin
        wr_en       = 1'b1;
        wr_rec.free = 1'b0;
        if (split_q) begin
          wr_rec.size = need_q;
          wr_rec.next = {1'b0, new_q};
        end
        fin_en    = 1'b1;
        fin_paddr = ADDR_W'({1'b0, hit_q.start} + HDR_S);
        fin_gsize = wr_rec.size;
      end
      CMD_MNEXT: begin
        if (rd_live && rd_rec.free) begin
          clr_en   = 1'b1;
          clr_slot = rd_slot;
        end
      end
      CMD_MPREV: begin
        wr_en  = 1'b1;
        fin_en = 1'b1;
        if (prv_q && prv_rec_q.free) begin
          wr_slot     = prv_slot_q;
          wr_rec      = prv_rec_q;
          wr_rec.size = merged_size;
          wr_rec.next = hit_q.next;
          clr_en      = 1'b1;
        end else begin
          wr_rec.free = 1'b1;
        end
        fin_paddr = ADDR_W'({1'b0, wr_rec.start} + HDR_S);
        fin_gsize = wr_rec.size;
      end
      CMD_FIN: begin
        fin_en = 1'b1;
        unique case (op_q)
          OP_ALLOC: fin_status = STS_NO_FIT;
          OP_FREE:  fin_status = (addr_q == '0) ? STS_NULL : STS_UNKNOWN;
          OP_REINIT: begin
            do_init   = 1'b1;
            fin_paddr = ADDR_W'(HDR_S);
            fin_gsize = ARENA_S;
          end
          default: fin_status = STS_OK;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (do_init) begin
      valid_d = MAX_BLOCKS'(1);
    end else begin
      if (clr_en) valid_d[clr_slot] = 1'b0;
      if (wr_en) valid_d[wr_slot] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 1; i < MAX_BLOCKS; i++) begin
        tab_q[i] <= '{start: '0, size: '0, free: 1'b0, next: CHAIN_END};
      end
      tab_q[0]   <= '{start: '0, size: ARENA_S, free: 1'b1, next: CHAIN_END};
      valid_q    <= MAX_BLOCKS'(1);
      mode_q     <= MODE_FIRST;
    end else begin
      if (cfg_we_i) mode_q <= cfg_mode_i;
      valid_q <= valid_d;
      if (do_init) begin
        tab_q[0] <= '{start: '0, size: ARENA_S, free: 1'b1, next: CHAIN_END};
      end else if (wr_en) begin
        tab_q[wr_slot] <= wr_rec;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q    <= OP_ALLOC;
      cur_q   <= '0;
      steps_q <= '0;
      stop_q  <= 1'b0;
      found_q <= 1'b0;
      prv_q   <= 1'b0;
      split_q <= 1'b0;
    end else begin
      unique case (cmd_i.cmd)
        CMD_LOAD: begin
          op_q    <= op_i;
          cur_q   <= '0;
          steps_q <= '0;
          stop_q  <= 1'b0;
          found_q <= 1'b0;
          prv_q   <= 1'b0;
        end
        CMD_WALK: begin
          cur_q   <= rd_rec.next;
          steps_q <= steps_q + 1'b1;
          if (op_q == OP_ALLOC) begin
            if (take_alloc) begin
              found_q <= 1'b1;
              if (mode_q == MODE_FIRST) stop_q <= 1'b1;
            end
          end else if (match) begin
            found_q <= 1'b1;
            stop_q  <= 1'b1;
          end else begin
            prv_q <= 1'b1;
          end
        end
        CMD_SPLIT: split_q <= split_cond && spare_ok;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.cmd)
      CMD_LOAD: begin
        need_q <= need_i;
        addr_q <= addr_i;
      end
      CMD_WALK: begin
        if ((op_q == OP_ALLOC) ? take_alloc : match) begin
          hit_slot_q <= rd_slot;
          hit_q      <= rd_rec;
        end else if (op_q != OP_ALLOC) begin
          prv_slot_q <= rd_slot;
          prv_rec_q  <= rd_rec;
        end
      end
      CMD_SPLIT: new_q <= spare_slot;
      CMD_MNEXT: begin
        if (rd_live && rd_rec.free) begin
          hit_q.size <= hit_q.size + HDR_S + rd_rec.size;
          hit_q.next <= rd_rec.next;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_en) begin
      out_status_q <= fin_status;
      out_paddr_q  <= fin_paddr;
      out_gsize_q  <= fin_gsize;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_paddr_o  = out_paddr_q;
  assign out_gsize_o  = out_gsize_q;

endmodule

// ===== sv/fit_policy_block_allocator.sv =====
// Top level of the fit policy block allocator.
// Manages a 1024-byte arena as an address-ordered chain of up to 32 block records with a
// 24-byte header each; fit_mode (to be written on the cfg channel only while idle, which the
// block itself does not enforce) selects first, best or worst fit. One request is taken at a
// time: a request walks the chain one record per clock, and an allocate or free that finds its
// block then goes on to split or merge, while reinitialize, null and unused requests skip the
// walk. The result sits in an output register; a stalled result holds the sequencer, and the
// next request is taken once the sequencer is back to idle.
`timescale 1ns / 1ps
module fit_policy_block_allocator import fpba_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // request_size[10:0], free_address[20:11], zero pad
  input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // payload_address[9:0], granted_size[20:10], zero pad
  output logic [1:0]  m_axis_tuser,  // status[1:0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i
);

  fpba_cmd_t         cmd;
  fpba_sts_t         sts;
  logic [STS_W-1:0]  out_status;
  logic [ADDR_W-1:0] out_paddr;
  logic [SIZE_W-1:0] out_gsize;

  assign cfg_ready_o = 1'b1;

  fpba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fpba_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .op_i         (s_axis_tuser),
    .need_i       (s_axis_tdata[10:0]),
    .addr_i       (s_axis_tdata[20:11]),
    .cfg_we_i     (cfg_valid_i),
    .cfg_mode_i   (cfg_data_i),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_paddr_o  (out_paddr),
    .out_gsize_o  (out_gsize)
  );

  assign m_axis_tdata = {3'b000, out_gsize, out_paddr};
  assign m_axis_tuser = out_status;

endmodule

// ===== sv/fpba_chk.sv =====
// Port-level checker of the fit policy block allocator, bound to the top level.
`timescale 1ns / 1ps
module fpba_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result word changed");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while previous one in progress");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != 2'd0) |-> (m_axis_tdata == 24'd0))
    else $error("error result carries nonzero data");

  a_ok_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == 2'd0) && (m_axis_tdata[20:10] != 11'd0)
      |-> (m_axis_tdata[9:0] >= 10'd24))
    else $error("granted block below first header");

endmodule

bind fit_policy_block_allocator fpba_chk u_fpba_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
